[rtl/core/ntpsr_pkg.sv]
// shared types, codes and constants of the sntp server responder
package ntpsr_pkg;

  // input opcodes
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_REQ  = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  localparam int unsigned PKT_LEN     = 48;
  localparam int unsigned STAMP_POS   = 40;
  localparam int unsigned STAMP_LEN   = 8;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned MS_W        = 10;
  localparam int unsigned JOBQ_DEPTH  = 4;
  localparam int unsigned JOBQ_PTR_W  = $clog2(JOBQ_DEPTH);

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(PKT_LEN - 1);
  localparam logic [CNT_W-1:0] PKT_LEN_C  = CNT_W'(PKT_LEN);
  localparam logic [CNT_W-1:0] STAMP_POS_C = CNT_W'(STAMP_POS);
  localparam logic [MS_W-1:0]  MS_MAX     = MS_W'(999);
  localparam logic [31:0]      NTP_EPOCH_OFFSET = 32'd2208988800;

  // fixed reply bytes
  localparam logic [7:0] HDR_LI_VN_MODE = 8'h24;
  localparam logic [7:0] HDR_STRATUM    = 8'd1;
  localparam logic [7:0] HDR_POLL       = 8'd6;
  localparam logic [7:0] HDR_PRECISION  = 8'hEC;
  localparam logic [7:0] REF_ID_0       = 8'h4C;  // L
  localparam logic [7:0] REF_ID_1       = 8'h4F;  // O
  localparam logic [7:0] REF_ID_2       = 8'h43;  // C
  localparam logic [7:0] REF_ID_3       = 8'h32;  // 2

  // 2^32 = FRAC_INT * 1000 + FRAC_REM
  localparam logic [31:0] FRAC_INT   = 32'd4294967;
  localparam logic [18:0] FRAC_REM   = 19'd296;
  // floor(y / 1000) estimate: (y * RECIP_1000) >> RECIP_SHIFT, at most one high
  localparam logic [10:0] RECIP_1000  = 11'd1049;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam logic [18:0] THOUSAND    = 19'd1000;

  // one reply to build
  typedef struct packed {
    logic [31:0]           sec1900;
    logic [MS_W-1:0]       ms;
    logic [STAMP_LEN-1:0][7:0] stamp;
  } job_t;

endpackage

[rtl/core/ntp_server_responder.sv]
// top level of the sntp server responder
// Takes one item per cycle: millisecond ticks, set-time loads and request
// bytes. When the last byte of a request of at least 48 bytes arrives while
// the clock holds a valid nonzero time, a 48-byte SNTPv4 server reply is
// queued and delivered one byte per transfer. The reply builder streams one
// byte per cycle, so requests of 48 bytes or more back to back never stall
// while the receiver takes a byte every cycle; full rises only when four
// replies, the one being sent included, wait in the job queue, and it then
// holds off every kind of item.
module ntp_server_responder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 opcode,
  input  logic [7:0]                 req_byte,
  input  logic                       req_last,
  input  logic [31:0]                set_unix_sec,
  input  logic [ntpsr_pkg::MS_W-1:0] set_ms,
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 resp_byte,
  output logic [ntpsr_pkg::IDX_W-1:0] resp_index,
  output logic                       resp_last
);
  import ntpsr_pkg::*;

  logic accept;
  logic job_push, job_pop, jq_empty;
  job_t job_in, job_head;

  assign accept = push && !full;

  // front: clock and request tracking
  ntpsr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .opcode       (opcode),
    .req_byte     (req_byte),
    .req_last     (req_last),
    .set_unix_sec (set_unix_sec),
    .set_ms       (set_ms),
    .job_push     (job_push),
    .job          (job_in)
  );

  // reply jobs in flight
  ntpsr_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (full),
    .pop   (job_pop),
    .empty (jq_empty),
    .head  (job_head)
  );

  // back: reply serializer
  ntpsr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_avail  (!jq_empty),
    .job        (job_head),
    .job_pop    (job_pop),
    .pop        (pop),
    .empty      (empty),
    .resp_byte  (resp_byte),
    .resp_index (resp_index),
    .resp_last  (resp_last)
  );

endmodule

[rtl/core/ntpsr_front.sv]
// front part: clock keeping, request tracking and reply job creation
module ntpsr_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [1:0]               opcode,
  input  logic [7:0]               req_byte,
  input  logic                     req_last,
  input  logic [31:0]              set_unix_sec,
  input  logic [ntpsr_pkg::MS_W-1:0] set_ms,
  output logic                     job_push,
  output ntpsr_pkg::job_t          job
);
  import ntpsr_pkg::*;

  logic [31:0]      unix_seconds, unix_seconds_next;
  logic [MS_W-1:0]  milli_count, milli_count_next;
  logic             time_valid, time_valid_next;
  logic [CNT_W-1:0] request_count, request_count_next;
  logic [STAMP_LEN-1:0][7:0] client_stamp, client_stamp_next;
  logic [CNT_W-1:0] count_upd;
  logic             stamp_wr;
  opcode_t          op;

  assign op = opcode_t'(opcode);

  // request byte counting and stamp capture
  always_comb begin
    stamp_wr          = (request_count < PKT_LEN_C) && (request_count >= STAMP_POS_C);
    client_stamp_next = client_stamp;
    if (stamp_wr) begin
      client_stamp_next[request_count[2:0]] = req_byte;
    end
    count_upd = (request_count < PKT_LEN_C) ? request_count + CNT_W'(1) : request_count;
  end

  // next state of clock and request tracking
  always_comb begin
    unix_seconds_next  = unix_seconds;
    milli_count_next   = milli_count;
    time_valid_next    = time_valid;
    request_count_next = request_count;
    job_push           = 1'b0;
    if (accept) begin
      unique case (op)
        OP_TICK: begin
          if (time_valid) begin
            if (milli_count >= MS_MAX) begin
              milli_count_next  = '0;
              unix_seconds_next = unix_seconds + 32'd1;
            end else begin
              milli_count_next = milli_count + MS_W'(1);
            end
          end
        end
        OP_SET: begin
          unix_seconds_next = set_unix_sec;
          milli_count_next  = (set_ms > MS_MAX) ? MS_MAX : set_ms;
          time_valid_next   = (set_unix_sec != 32'd0);
        end
        OP_REQ: begin
          request_count_next = count_upd;
          if (req_last) begin
            request_count_next = '0;
            job_push = (count_upd >= PKT_LEN_C) && time_valid && (unix_seconds != 32'd0);
          end
        end
        OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // job snapshot, stamp includes the byte of this transfer
  always_comb begin
    job.sec1900 = unix_seconds + NTP_EPOCH_OFFSET;
    job.ms      = milli_count;
    job.stamp   = client_stamp_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      unix_seconds  <= '0;
      milli_count   <= '0;
      time_valid    <= 1'b0;
      request_count <= '0;
    end else begin
      unix_seconds  <= unix_seconds_next;
      milli_count   <= milli_count_next;
      time_valid    <= time_valid_next;
      request_count <= request_count_next;
    end
  end

  // stamp bytes hold no reset
  always_ff @(posedge clk) begin
    if (accept && (op == OP_REQ)) begin
      client_stamp <= client_stamp_next;
    end
  end

endmodule

[rtl/core/ntpsr_jobq.sv]
// short queue of reply jobs between front and back
module ntpsr_jobq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ntpsr_pkg::job_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output ntpsr_pkg::job_t head
);
  import ntpsr_pkg::*;

  job_t                  slots [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [JOBQ_PTR_W:0]   count;

  assign full  = (count == (JOBQ_PTR_W+1)'(JOBQ_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + JOBQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + JOBQ_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (JOBQ_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (JOBQ_PTR_W+1)'(1);
      end
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // no write into a full queue, no read from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("job popped from empty queue");

endmodule

[rtl/core/ntpsr_back.sv]
// back part: serializes one reply job into 48 bytes behind an output register
module ntpsr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_avail,
  input  ntpsr_pkg::job_t           job,
  output logic                      job_pop,
  input  logic                      pop,
  output logic                      empty,
  output logic [7:0]                resp_byte,
  output logic [ntpsr_pkg::IDX_W-1:0] resp_index,
  output logic                      resp_last
);
  import ntpsr_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             out_valid;
  logic             advance;
  logic             out_load;
  logic [7:0]       byte_sel;

  // fraction pipeline: frac = ms*FRAC_INT + floor(ms*FRAC_REM/1000)
  logic [31:0]      p_int, p_int_d;
  logic [18:0]      y, y_d;
  logic [9:0]       q_est;
  logic [31:0]      frac;
  logic [29:0]      q_prod;
  logic [18:0]      q_back;

  assign advance  = !out_valid || pop;
  assign out_load = advance && job_avail;
  assign job_pop  = out_load && (idx == LAST_IDX);
  assign empty    = !out_valid;

  always_comb begin
    q_prod = 30'(y) * 30'(RECIP_1000);
    q_back = 19'(q_est) * THOUSAND;
  end

  always_ff @(posedge clk) begin
    p_int   <= 32'(job.ms) * FRAC_INT;
    y       <= 19'(job.ms) * FRAC_REM;
    p_int_d <= p_int;
    y_d     <= y;
    q_est   <= 10'(q_prod >> RECIP_SHIFT);
    frac    <= p_int_d + 32'(q_est) - ((q_back > y_d) ? 32'd1 : 32'd0);
  end

  // reply byte at the current position
  always_comb begin
    byte_sel = 8'd0;
    unique case (idx)
      6'd0:  byte_sel = HDR_LI_VN_MODE;
      6'd1:  byte_sel = HDR_STRATUM;
      6'd2:  byte_sel = HDR_POLL;
      6'd3:  byte_sel = HDR_PRECISION;
      6'd12: byte_sel = REF_ID_0;
      6'd13: byte_sel = REF_ID_1;
      6'd14: byte_sel = REF_ID_2;
      6'd15: byte_sel = REF_ID_3;
      6'd24, 6'd25, 6'd26, 6'd27,
      6'd28, 6'd29, 6'd30, 6'd31: byte_sel = job.stamp[idx[2:0]];
      6'd32, 6'd40: byte_sel = job.sec1900[31:24];
      6'd33, 6'd41: byte_sel = job.sec1900[23:16];
      6'd34, 6'd42: byte_sel = job.sec1900[15:8];
      6'd35, 6'd43: byte_sel = job.sec1900[7:0];
      6'd36, 6'd44: byte_sel = frac[31:24];
      6'd37, 6'd45: byte_sel = frac[23:16];
      6'd38, 6'd46: byte_sel = frac[15:8];
      6'd39, 6'd47: byte_sel = frac[7:0];
      default:      byte_sel = 8'd0;
    endcase
  end

  // position counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= job_avail;
      end
      if (out_load) begin
        idx <= (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      resp_byte  <= byte_sel;
      resp_index <= idx;
      resp_last  <= (idx == LAST_IDX);
    end
  end

  // position stays inside the reply, a waiting byte is held, job leaves after its last byte
  a_idx_range: assert property (@(posedge clk) disable iff (rst) idx <= LAST_IDX)
    else $error("reply position out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
      out_valid && !pop |=> out_valid && $stable(resp_index) && $stable(resp_byte))
    else $error("waiting reply byte changed");
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
      job_pop |=> out_valid && resp_last)
    else $error("job released before its last byte");

endmodule

[dv/ntp_server_responder_tb.sv]
// testbench for the sntp server responder: directed table, then random traffic checked by a predictor
`timescale 1ns / 100ps

module ntp_server_responder_tb;

  import ntpsr_pkg::*;

  // reply layout as the protocol fixes it
  localparam int unsigned REPLY_LEN  = 48;
  localparam int unsigned STAMP_AT   = 40;
  localparam logic [MS_W-1:0] MS_TOP = 10'd999;
  localparam logic [31:0] EPOCH_1900 = 32'd2208988800;
  localparam logic [7:0] LI_VN_MODE  = 8'h24;
  localparam logic [7:0] STRATUM_1   = 8'd1;
  localparam logic [7:0] POLL_6      = 8'd6;
  localparam logic [7:0] PREC_M20    = 8'hEC;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RAND_QUOTA   = 32;

  typedef struct {
    opcode_t         op;
    logic [7:0]      data;
    logic            last;
    logic [31:0]     sec;
    logic [MS_W-1:0] ms;
  } item_t;

  typedef struct packed {
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic             last;
  } reply_byte_t;

  // one directed row; request rows send a whole frame of len bytes
  typedef struct {
    opcode_t         op;
    logic [7:0]      data;
    logic [7:0]      step;
    int unsigned     len;
    logic            last;
    logic [31:0]     sec;
    logic [MS_W-1:0] ms;
    bit              no_reply;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [1:0]            opcode = 2'd0;
  logic [7:0]            req_byte = 8'd0;
  logic                  req_last = 1'b0;
  logic [31:0]           set_unix_sec = 32'd0;
  logic [MS_W-1:0]       set_ms = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [7:0]            resp_byte;
  logic [IDX_W-1:0]      resp_index;
  logic                  resp_last;

  // predictor state
  logic [31:0]     clk_sec = 32'd0;
  logic [MS_W-1:0] clk_ms = '0;
  bit              clk_valid = 1'b0;
  int unsigned     rx_count = 0;
  logic [7:0]      rx_stamp [8] = '{default: 8'h00};

  reply_byte_t reply_q [$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_plan [4] = '{0, 78, 0, 11};
  int unsigned stall_plan [4] = '{0, 0, 78, 11};

  dir_row_t dir_tab [13] = '{
    '{OP_TICK, 8'hFF, 8'h00, 1,  1'b1, 32'hFFFFFFFF, 10'h3FF,  1'b1},  // tick without time
    '{OP_NONE, 8'hFF, 8'h00, 1,  1'b1, 32'h12345678, 10'h3FF,  1'b1},  // unknown opcode
    '{OP_SET,  8'h00, 8'h00, 1,  1'b0, 32'h00000000, 10'd5,    1'b1},  // zero seconds, no time
    '{OP_REQ,  8'hFF, 8'h00, 48, 1'b1, 32'h00000000, 10'd0,    1'b1},  // full request, no time
    '{OP_SET,  8'h00, 8'h00, 1,  1'b0, 32'h00000001, 10'h3FF,  1'b1},  // ms clamped to 999
    '{OP_TICK, 8'h00, 8'h00, 1,  1'b0, 32'h00000000, 10'd0,    1'b1},  // rollover into next second
    '{OP_REQ,  8'h5A, 8'h03, 49, 1'b1, 32'h00000000, 10'd0,    1'b0},  // long request
    '{OP_REQ,  8'h11, 8'h00, 1,  1'b1, 32'h00000000, 10'd0,    1'b1},  // lone last byte
    '{OP_REQ,  8'h00, 8'h00, 47, 1'b1, 32'h00000000, 10'd0,    1'b1},  // short request
    '{OP_SET,  8'h00, 8'h00, 1,  1'b0, 32'hFFFFFFFF, 10'd999,  1'b1},
    '{OP_REQ,  8'h00, 8'h00, 48, 1'b1, 32'h00000000, 10'd0,    1'b0},
    '{OP_TICK, 8'h00, 8'h00, 1,  1'b0, 32'h00000000, 10'd0,    1'b1},  // seconds wrap to zero
    '{OP_REQ,  8'hA5, 8'h01, 48, 1'b1, 32'h00000000, 10'd0,    1'b1}   // wrapped clock, no reply
  };

  ntp_server_responder u_top (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .opcode       (opcode),
    .req_byte     (req_byte),
    .req_last     (req_last),
    .set_unix_sec (set_unix_sec),
    .set_ms       (set_ms),
    .empty        (empty),
    .pop          (pop),
    .resp_byte    (resp_byte),
    .resp_index   (resp_index),
    .resp_last    (resp_last)
  );

  always #2 clk = ~clk;

  // advance the predicted clock and request state by one item, queue any reply
  task automatic apply_item(input item_t it, input bit queue_reply);
    logic [7:0]  pkt [REPLY_LEN];
    logic [31:0] sec1900;
    logic [31:0] frac;
    logic [63:0] scaled;
    bit          complete;
    case (it.op)
      OP_TICK: begin
        if (clk_valid) begin
          if (clk_ms == MS_TOP) begin
            clk_ms = '0;
            clk_sec = clk_sec + 32'd1;
          end else begin
            clk_ms = clk_ms + MS_W'(1);
          end
        end
      end
      OP_SET: begin
        clk_sec = it.sec;
        clk_ms = (it.ms > MS_TOP) ? MS_TOP : it.ms;
        clk_valid = (it.sec != 32'd0);
      end
      OP_REQ: begin
        if (rx_count < REPLY_LEN) begin
          if (rx_count >= STAMP_AT) rx_stamp[rx_count - STAMP_AT] = it.data;
          rx_count++;
        end
        if (it.last) begin
          complete = (rx_count >= REPLY_LEN);
          rx_count = 0;
          if (complete && clk_valid && clk_sec != 32'd0 && queue_reply) begin
            sec1900 = clk_sec + EPOCH_1900;
            scaled = {22'd0, clk_ms, 32'd0} / 64'd1000;
            frac = scaled[31:0];
            foreach (pkt[i]) pkt[i] = 8'h00;
            pkt[0] = LI_VN_MODE;
            pkt[1] = STRATUM_1;
            pkt[2] = POLL_6;
            pkt[3] = PREC_M20;
            pkt[12] = "L";
            pkt[13] = "O";
            pkt[14] = "C";
            pkt[15] = "2";
            for (int k = 0; k < 8; k++) pkt[24 + k] = rx_stamp[k];
            // receive and transmit stamps are identical, big endian
            for (int k = 0; k < 4; k++) begin
              pkt[32 + k] = sec1900[31 - 8 * k -: 8];
              pkt[36 + k] = frac[31 - 8 * k -: 8];
              pkt[40 + k] = sec1900[31 - 8 * k -: 8];
              pkt[44 + k] = frac[31 - 8 * k -: 8];
            end
            for (int i = 0; i < REPLY_LEN; i++)
              reply_q.push_back('{data: pkt[i], index: IDX_W'(i), last: (i == REPLY_LEN - 1)});
          end
        end
      end
      default: ;
    endcase
  endtask

  // drive one item from a falling edge and hold it until the transfer
  task automatic send_item(input item_t it, input bit queue_reply);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    opcode <= it.op;
    req_byte <= it.data;
    req_last <= it.last;
    set_unix_sec <= it.sec;
    set_ms <= it.ms;
    @(posedge clk);
    while (full) @(posedge clk);
    apply_item(it, queue_reply);
    items_sent++;
    @(negedge clk);
  endtask

  // tick or unknown opcode with random payload
  function automatic item_t stray_item();
    item_t it;
    it.op = ($urandom_range(1) == 0) ? OP_TICK : OP_NONE;
    it.data = 8'($urandom);
    it.last = 1'($urandom);
    it.sec = $urandom;
    it.ms = MS_W'($urandom);
    return it;
  endfunction

  // one request frame, last flag on the final byte
  task automatic send_frame(input int unsigned len, input logic [7:0] base,
                            input logic [7:0] step, input bit rnd, input bit queue_reply);
    item_t it;
    for (int unsigned i = 0; i < len; i++) begin
      // stray ticks and unknown items inside a frame
      if (rnd && $urandom_range(31) == 0) send_item(stray_item(), 1'b1);
      it.op = OP_REQ;
      it.data = rnd ? 8'($urandom) : base + 8'(i) * step;
      it.last = (i == len - 1);
      it.sec = $urandom;
      it.ms = MS_W'($urandom);
      send_item(it, queue_reply);
    end
  endtask

  // random traffic, mostly well-formed requests, until the running item count reaches goal
  task automatic run_random(input int unsigned goal);
    int unsigned pick;
    int unsigned len;
    int unsigned n;
    item_t       it;
    do begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        case ($urandom_range(9))
          7:       len = $urandom_range(40, 47);
          8:       len = $urandom_range(49, 56);
          9:       len = $urandom_range(1, 8);
          default: len = REPLY_LEN;
        endcase
        send_frame(len, 8'h00, 8'h00, 1'b1, 1'b1);
      end else if (pick < 72) begin
        n = $urandom_range(1, 12);
        repeat (n) begin
          it = stray_item();
          it.op = OP_TICK;
          send_item(it, 1'b1);
        end
      end else if (pick < 87) begin
        it = stray_item();
        it.op = OP_SET;
        case ($urandom_range(9))
          0:       it.sec = 32'd0;
          1:       it.sec = 32'hFFFFFFFF;
          default: it.sec = $urandom;
        endcase
        it.ms = ($urandom_range(1) == 0) ? MS_W'($urandom_range(1023))
                                         : MS_W'($urandom_range(985, 1023));
        send_item(it, 1'b1);
      end else if (pick < 94) begin
        // broken frame: a last byte at a random point
        it = stray_item();
        it.op = OP_REQ;
        it.last = 1'b1;
        send_item(it, 1'b1);
      end else begin
        it = stray_item();
        it.op = OP_NONE;
        send_item(it, 1'b1);
      end
    end while (items_sent < goal);
  endtask

  // hold off the sender until every expected reply byte has come
  task automatic wait_drain();
    push <= 1'b0;
    @(negedge clk);
    while (reply_q.size() != 0) @(negedge clk);
  endtask

  // receiver readiness, changed at the falling edge
  always @(negedge clk) begin
    pop <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each result transfer with the oldest expected reply byte
  always @(posedge clk) begin
    reply_byte_t want;
    if (!rst && pop && !empty) begin
      if (reply_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: byte %02h index %0d last %0b",
                   resp_byte, resp_index, resp_last);
      end else begin
        want = reply_q.pop_front();
        if (resp_byte !== want.data || resp_index !== want.index || resp_last !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected byte %02h index %0d last %0b, got %02h %0d %0b",
                     want.data, want.index, want.last, resp_byte, resp_index, resp_last);
        end
      end
    end
  end

  // stimulus: directed table, then random phases with different idling
  initial begin
    dir_row_t    row;
    item_t       it;
    int unsigned dir_items;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    foreach (dir_tab[r]) begin
      row = dir_tab[r];
      if (row.op == OP_REQ) begin
        send_frame(row.len, row.data, row.step, 1'b0, !row.no_reply);
      end else begin
        it = '{op: row.op, data: row.data, last: row.last, sec: row.sec, ms: row.ms};
        send_item(it, !row.no_reply);
      end
    end
    wait_drain();
    dir_items = items_sent;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      run_random(dir_items + RAND_QUOTA * (p + 1));
      wait_drain();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("** ntp_server_responder: PASSED **");
    end else begin
      $display("** ntp_server_responder: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("** ntp_server_responder: FAILED **");
    $finish;
  end

endmodule
